// ----- rtl/core/rvc_pkg.sv -----
// Shared types and constants for the range value count block.
package rvc_pkg;

	localparam int DEPTH_DEFAULT = 1024;
	localparam int POS_W         = 11;
	localparam int VALUE_W       = 32;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	localparam logic [POS_W-1:0] COUNT_MAX = {POS_W{1'b1}};

	typedef struct packed {
		logic [1:0]               action;
		logic signed [VALUE_W-1:0] item_value;
		logic [POS_W-1:0]         range_start;
		logic [POS_W-1:0]         range_end;
	} rvc_in_t;

	typedef struct packed {
		logic [POS_W-1:0] match_count;
		logic             overflow_flag;
	} rvc_out_t;

	typedef enum logic [1:0] {
		CMD_CLEAR,
		CMD_APPEND,
		CMD_QUERY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   first;
		logic [POS_W-1:0]   last;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_beat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_FLUSH,
		BK_DONE
	} back_state_t;

endpackage

// ----- rtl/core/rvc_front.sv -----
// Front end: accepts input beats, classifies them and queues commands.
module rvc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rvc_pkg::rvc_in_t in_data,
	output rvc_pkg::cmd_beat_t cmd_out,
	input  logic            cmd_pop
);
	import rvc_pkg::*;

	cmd_t       q_mem [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cmd_new;
	logic       keep;
	logic       push;
	logic       pop;

	always_comb begin
		cmd_new.value = in_data.item_value;
		cmd_new.first = (in_data.range_start == '0) ? POS_W'(1) : in_data.range_start;
		cmd_new.last  = in_data.range_end;
		cmd_new.kind  = CMD_CLEAR;
		keep          = 1'b1;
		unique case (in_data.action)
			ACT_CLEAR:  cmd_new.kind = CMD_CLEAR;
			ACT_APPEND: cmd_new.kind = CMD_APPEND;
			ACT_QUERY:  cmd_new.kind = CMD_QUERY;
			default:    keep = 1'b0;
		endcase
	end

	assign in_ready      = (cnt_q != 2'(QUEUE_DEPTH));
	assign push          = in_valid && in_ready && keep;
	assign pop           = cmd_pop && (cnt_q != '0);
	assign cmd_out.valid = (cnt_q != '0);
	assign cmd_out.cmd   = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ----- rtl/core/rvc_back.sv -----
// Back end: element memory, fill count, range scan and result register.
module rvc_back #(
	parameter int DEPTH = rvc_pkg::DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rvc_pkg::cmd_beat_t cmd_in,
	output logic               cmd_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output rvc_pkg::rvc_out_t  out_data
);
	import rvc_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	logic [VALUE_W-1:0] mem [DEPTH];
	back_state_t        state_q;
	back_state_t        state_d;
	logic [CW-1:0]      fill_q;
	logic [PW-1:0]      pos_q;
	logic [PW-1:0]      last_q;
	logic [VALUE_W-1:0] target_q;
	logic [POS_W-1:0]   hits_q;
	logic               ovf_q;
	logic [VALUE_W-1:0] rd_data_s1;
	logic               rd_valid_s1;
	logic               out_valid_q;
	rvc_out_t           out_data_q;
	logic               room;
	logic [PW-1:0]      first_x;
	logic [PW-1:0]      last_c;
	logic               rd_en;
	logic               res_load;
	logic               do_write;
	logic               do_clear;
	logic               start_query;
	logic               start_ovf;
	logic [AW-1:0]      rd_addr;

	assign room    = (fill_q < CW'(DEPTH));
	assign first_x = PW'(cmd_in.cmd.first);
	assign last_c  = (PW'(cmd_in.cmd.last) > PW'(fill_q)) ? PW'(fill_q) : PW'(cmd_in.cmd.last);
	assign rd_addr = AW'(pos_q - PW'(1));

	always_comb begin
		state_d     = state_q;
		cmd_pop     = 1'b0;
		rd_en       = 1'b0;
		res_load    = 1'b0;
		do_write    = 1'b0;
		do_clear    = 1'b0;
		start_query = 1'b0;
		start_ovf   = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_in.valid) begin
					cmd_pop = 1'b1;
					unique case (cmd_in.cmd.kind)
						CMD_CLEAR: begin
							do_clear = 1'b1;
						end
						CMD_APPEND: begin
							if (room) begin
								do_write = 1'b1;
							end else begin
								start_ovf = 1'b1;
								state_d   = BK_DONE;
							end
						end
						CMD_QUERY: begin
							start_query = 1'b1;
							state_d     = (first_x > last_c) ? BK_DONE : BK_SCAN;
						end
						default: ;
					endcase
				end
			end
			BK_SCAN: begin
				rd_en = 1'b1;
				if (pos_q == last_q) begin
					state_d = BK_FLUSH;
				end
			end
			BK_FLUSH: begin
				state_d = BK_DONE;
			end
			BK_DONE: begin
				if (!out_valid_q || out_ready) begin
					res_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[fill_q[AW-1:0]] <= cmd_in.cmd.value;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (start_query) begin
			pos_q    <= first_x;
			last_q   <= last_c;
			target_q <= cmd_in.cmd.value;
			hits_q   <= '0;
			ovf_q    <= 1'b0;
		end else if (start_ovf) begin
			hits_q <= '0;
			ovf_q  <= 1'b1;
		end else begin
			if (rd_en) begin
				pos_q <= pos_q + PW'(1);
			end
			if (rd_valid_s1 && rd_data_s1 == target_q && hits_q != COUNT_MAX) begin
				hits_q <= hits_q + POS_W'(1);
			end
		end
		if (res_load) begin
			out_data_q.match_count   <= hits_q;
			out_data_q.overflow_flag <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			fill_q      <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= rd_en;
			if (do_clear) begin
				fill_q <= '0;
			end else if (do_write) begin
				fill_q <= fill_q + CW'(1);
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ----- rtl/core/range_value_count.sv -----
// Top level of the range value count block.
//
// Input beats carry an action (clear, append, query), a value and an
// inclusive one-based position range. Append stores the value at the next
// position; a query returns how many loaded elements in the range equal the
// value. An append to a full store and every query each give one output beat.
// A front end classifies beats into a two-entry command queue, so input is
// accepted while the back end scans or while a result waits to be taken.
// Clear and an append with room complete in the back end's idle state. A
// query passes through the scan, flush and done states: the scan reads its
// clipped range one position at a time through the single read port of the
// element memory, the flush counts the last word read and the done state
// loads the result register. A query with an empty range and an append to a
// full store skip the scan and go straight to the done state.
// Reset empties the store and the queue and drops any pending result; the
// memory contents are not cleared. When the receiver holds out_ready low the
// result stays in the output register, the back end stops at its next result
// and the front end stalls once the queue is full.
module range_value_count #(
	parameter int DEPTH = rvc_pkg::DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rvc_pkg::rvc_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rvc_pkg::rvc_out_t out_data
);
	import rvc_pkg::*;

	cmd_beat_t cmd_beat;
	logic      cmd_pop;

	rvc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cmd_out  (cmd_beat),
		.cmd_pop  (cmd_pop)
	);

	rvc_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_in    (cmd_beat),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- rtl/core/rvc_checker.sv -----
// Port-level checks for the range value count block, bound to the top level.
module rvc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input rvc_pkg::rvc_in_t  in_data,
	input logic              out_valid,
	input logic              out_ready,
	input rvc_pkg::rvc_out_t out_data
);
	import rvc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("Output beat changed while stalled.");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("Input beat changed while stalled.");

	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.overflow_flag |-> out_data.match_count == '0)
		else $error("Overflow beat carries a nonzero count.");

	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("Output beat valid right after reset.");

endmodule

bind range_value_count rvc_checker u_rvc_checker (.*);
